>>> hw/rtl/pu8_pkg.sv
`default_nettype none
package pu8_pkg;

    // Width of the byte_count field.
    localparam int unsigned COUNT_W = 11;

    localparam logic [7:0]  LEAD2_MASK   = 8'he0;
    localparam logic [7:0]  LEAD2_CODE   = 8'hc0;
    localparam logic [7:0]  LEAD2_MIN    = 8'hc2;
    localparam logic [7:0]  LEAD3_MASK   = 8'hf0;
    localparam logic [7:0]  LEAD3_CODE   = 8'he0;
    localparam logic [7:0]  LEAD4_MASK   = 8'hf8;
    localparam logic [7:0]  LEAD4_CODE   = 8'hf0;
    localparam logic [7:0]  LEAD4_MAX    = 8'hf4;
    localparam logic [7:0]  CONT_MASK    = 8'hc0;
    localparam logic [7:0]  CONT_CODE    = 8'h80;
    localparam logic [7:0]  PRINT_MIN    = 8'h20;
    localparam logic [7:0]  ASCII_DEL    = 8'h7f;

    localparam logic [20:0] MIN_3BYTE    = 21'h000800;
    localparam logic [20:0] SURR_LO      = 21'h00d800;
    localparam logic [20:0] SURR_HI      = 21'h00dfff;
    localparam logic [20:0] MIN_4BYTE    = 21'h010000;
    localparam logic [20:0] MAX_SCALAR   = 21'h10ffff;

    localparam logic [1:0]  CONTS_TWO    = 2'd2;
    localparam logic [1:0]  CONTS_THREE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_data;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        logic               observed;
        logic               truncated;
        logic               malformed;
        logic [COUNT_W-1:0] byte_count;
    } summary_beat_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]  pending;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic        err;
    } dec_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/pu8_decode.sv
`default_nettype none
module pu8_decode
(
    input  wire pu8_pkg::dec_state_t cur,
    input  wire logic [7:0]          data_byte,
    input  wire logic                inspect,
    output pu8_pkg::dec_state_t      nxt
);

    logic [20:0] acc_shift;
    logic [1:0]  pending_dec;
    logic        scalar_ok;

    assign acc_shift   = {cur.acc[14:0], data_byte[5:0]};
    assign pending_dec = cur.pending - 2'd1;

    always_comb
    begin
        if (cur.seq_len == pu8_pkg::CONTS_TWO)
        begin
            scalar_ok = (acc_shift >= pu8_pkg::MIN_3BYTE) &&
                        !((acc_shift >= pu8_pkg::SURR_LO) && (acc_shift <= pu8_pkg::SURR_HI));
        end
        else if (cur.seq_len == pu8_pkg::CONTS_THREE)
        begin
            scalar_ok = (acc_shift >= pu8_pkg::MIN_4BYTE) &&
                        (acc_shift <= pu8_pkg::MAX_SCALAR);
        end
        else
        begin
            scalar_ok = 1'b1;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (inspect && !cur.err)
        begin
            if (cur.pending == 2'd0)
            begin
                priority if (!data_byte[7])
                begin
                    if ((data_byte < pu8_pkg::PRINT_MIN) || (data_byte == pu8_pkg::ASCII_DEL))
                        nxt.err = 1'b1;
                end
                else if (((data_byte & pu8_pkg::LEAD2_MASK) == pu8_pkg::LEAD2_CODE) &&
                         (data_byte >= pu8_pkg::LEAD2_MIN))
                begin
                    nxt.pending = 2'd1;
                    nxt.seq_len = 2'd1;
                    nxt.acc     = {16'd0, data_byte[4:0]};
                end
                else if ((data_byte & pu8_pkg::LEAD3_MASK) == pu8_pkg::LEAD3_CODE)
                begin
                    nxt.pending = pu8_pkg::CONTS_TWO;
                    nxt.seq_len = pu8_pkg::CONTS_TWO;
                    nxt.acc     = {17'd0, data_byte[3:0]};
                end
                else if (((data_byte & pu8_pkg::LEAD4_MASK) == pu8_pkg::LEAD4_CODE) &&
                         (data_byte <= pu8_pkg::LEAD4_MAX))
                begin
                    nxt.pending = pu8_pkg::CONTS_THREE;
                    nxt.seq_len = pu8_pkg::CONTS_THREE;
                    nxt.acc     = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    nxt.err = 1'b1;
                end
            end
            else if ((data_byte & pu8_pkg::CONT_MASK) != pu8_pkg::CONT_CODE)
            begin
                // A missing continuation closes the sequence as an error.
                nxt.err     = 1'b1;
                nxt.pending = 2'd0;
            end
            else
            begin
                nxt.acc     = acc_shift;
                nxt.pending = pending_dec;
                if ((pending_dec == 2'd0) && !scalar_ok)
                    nxt.err = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/printable_utf8_checker_top.sv
`default_nettype none
// Checks that the first MAX_BYTES bytes of a text form strict printable UTF-8 and
// emits one summary beat on the beat marked last. One byte beat is taken every
// clock cycle; the byte passes an input register, is decoded combinationally
// against the running decoder state, and the summary is written to the output
// register when the last beat leaves the input register. Intake pauses only when a
// last beat meets a summary that the sink has not yet taken.
module printable_utf8_checker_top
#(
    parameter int unsigned MAX_BYTES = 1024
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           byte_valid,
    output logic                          byte_ready,
    input  wire pu8_pkg::byte_beat_t      byte_data,
    output logic                          summary_valid,
    input  wire                           summary_ready,
    output pu8_pkg::summary_beat_t        summary_data
);

    localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2);
    localparam int unsigned EXT_W = (CNT_W > pu8_pkg::COUNT_W) ? CNT_W : pu8_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0] LIMIT_SAT = CNT_W'(MAX_BYTES + 1);

    logic                   in_vld_reg;
    pu8_pkg::byte_beat_t    in_reg;
    logic                   sum_vld_reg;
    pu8_pkg::summary_beat_t sum_reg;
    pu8_pkg::summary_beat_t sum_next;
    pu8_pkg::dec_state_t    state_reg;
    pu8_pkg::dec_state_t    state_next;
    pu8_pkg::dec_state_t    dec_out;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [EXT_W-1:0]       count_ext;
    logic                   out_free;
    logic                   advance;
    logic                   inspect;

    assign out_free   = !sum_vld_reg || summary_ready;
    assign advance    = in_vld_reg && (!in_reg.last || out_free);
    assign byte_ready = !in_vld_reg || advance;
    assign inspect    = !in_reg.no_data && (count_reg < LIMIT);

    pu8_decode u_decode
    (
        .cur       (state_reg),
        .data_byte (in_reg.data_byte),
        .inspect   (inspect),
        .nxt       (dec_out)
    );

    always_comb
    begin
        count_next = count_reg;
        if (!in_reg.no_data && (count_reg < LIMIT_SAT))
            count_next = count_reg + CNT_W'(1);
        count_ext = EXT_W'(count_next);

        sum_next.observed   = (count_next != '0);
        sum_next.truncated  = (count_next > LIMIT);
        sum_next.malformed  = dec_out.err || (dec_out.pending != 2'd0);
        sum_next.byte_count = count_ext[pu8_pkg::COUNT_W-1:0];

        // The end of a text returns all decoder state to its starting point.
        state_next = in_reg.last ? '0 : dec_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            state_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (byte_ready)
                in_vld_reg <= byte_valid;
            if (out_free)
                sum_vld_reg <= advance && in_reg.last;
            if (advance)
            begin
                state_reg <= state_next;
                count_reg <= in_reg.last ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_reg <= byte_data;
        if (out_free && advance && in_reg.last)
            sum_reg <= sum_next;
    end

    assign summary_valid = sum_vld_reg;
    assign summary_data  = sum_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT_SAT)
        else $error("byte counter passed its saturation value");

    a_pending_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending <= state_reg.seq_len)
        else $error("more continuations pending than the sequence holds");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.last) |=> (count_reg == '0) && (state_reg == '0))
        else $error("decoder state not cleared after the end of a text");

    a_summary_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.last) |=> sum_vld_reg)
        else $error("end of text produced no summary");

endmodule
`default_nettype wire
